>>> design/rc_serial_frame_decoder_unit_defines.svh
// Assertion macros used by the checker file of the frame decoder.
// No dependencies; include by bare file name.
`ifndef RC_SERIAL_FRAME_DECODER_UNIT_DEFINES_SVH
`define RC_SERIAL_FRAME_DECODER_UNIT_DEFINES_SVH

// Generic concurrent assertion, disabled while reset is asserted (active low).
`define RCSFD_ASSERT(lbl, clk, rstn, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) prop) \
    else $error(msg);

// Same-cycle implication built on the macro above.
`define RCSFD_IMPLY(lbl, clk, rstn, ante, cons, msg) \
  `RCSFD_ASSERT(lbl, clk, rstn, (ante) |-> (cons), msg)

`endif

>>> design/rcsfd_pkg.sv
// Shared constants, types and the CRC step function of the frame decoder.
// No dependencies.
`default_nettype none

package rcsfd_pkg;

  localparam int MAX_CHANNELS = 16;
  localparam int IDX_W        = $clog2(MAX_CHANNELS);

  localparam int IN_TDATA_W   = 8;
  localparam int OUT_TDATA_W  = 32;   // index 5 + value 16 + total 6, padded to bytes
  localparam int OUT_TUSER_W  = 2;

  localparam logic [7:0]  START_BYTE      = 8'hA8;
  localparam logic [7:0]  STATUS_LIVE     = 8'h01;
  localparam logic [7:0]  STATUS_FAILSAFE = 8'h81;
  localparam logic [15:0] CRC_POLY        = 16'h1021;
  localparam logic [15:0] CRC_TOP         = 16'h8000;
  localparam logic [7:0]  MIN_COUNT       = 8'd2;
  localparam logic [7:0]  MAX_COUNT       = 8'(MAX_CHANNELS);

  typedef struct packed {
    logic hunt_start;
    logic status_take;
    logic count_take;
    logic data_take;
    logic emit_step;
  } cmd_t;

  typedef struct packed {
    logic is_start;
    logic status_ok;
    logic count_ok;
    logic final_byte;
    logic emit_last;
    logic out_free;
  } sts_t;

  // CRC-16, poly 0x1021, MSB first, one byte.
  function automatic logic [15:0] crc_add(input logic [15:0] crc, input logic [7:0] b);
    logic [15:0] c;
    c = crc ^ {b, 8'h00};
    for (int k = 0; k < 8; k++) begin
      if ((c & CRC_TOP) != 16'h0000) begin
        c = {c[14:0], 1'b0} ^ CRC_POLY;
      end else begin
        c = {c[14:0], 1'b0};
      end
    end
    return c;
  endfunction

endpackage

`default_nettype wire

>>> design/rcsfd_ctrl.sv
// Frame parsing state machine of the frame decoder.
// Depends on rcsfd_pkg (cmd_t, sts_t).
`default_nettype none

module rcsfd_ctrl (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic          in_valid_i,
  output logic               in_ready_o,
  input  rcsfd_pkg::sts_t    sts_i,
  output rcsfd_pkg::cmd_t    cmd_o
);
  import rcsfd_pkg::*;

  typedef enum logic [4:0] {
    ST_HUNT   = 5'b00001,
    ST_STATUS = 5'b00010,
    ST_COUNT  = 5'b00100,
    ST_DATA   = 5'b01000,
    ST_EMIT   = 5'b10000
  } state_e;

  state_e state_q, state_d;
  logic   acc;

  assign in_ready_o = (state_q != ST_EMIT);
  assign acc        = in_valid_i && in_ready_o;

  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    unique case (state_q)
      ST_HUNT: begin
        if (acc && sts_i.is_start) begin
          cmd_o.hunt_start = 1'b1;
          state_d          = ST_STATUS;
        end
      end
      ST_STATUS: begin
        if (acc) begin
          if (sts_i.status_ok) begin
            cmd_o.status_take = 1'b1;
            state_d           = ST_COUNT;
          end else begin
            state_d = ST_HUNT;
          end
        end
      end
      ST_COUNT: begin
        if (acc) begin
          if (sts_i.count_ok) begin
            cmd_o.count_take = 1'b1;
            state_d          = ST_DATA;
          end else begin
            state_d = ST_HUNT;
          end
        end
      end
      ST_DATA: begin
        if (acc) begin
          cmd_o.data_take = 1'b1;
          if (sts_i.final_byte) state_d = ST_EMIT;
        end
      end
      ST_EMIT: begin
        if (sts_i.out_free) begin
          cmd_o.emit_step = 1'b1;
          if (sts_i.emit_last) state_d = ST_HUNT;
        end
      end
      default: state_d = ST_HUNT;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_HUNT;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

`default_nettype wire

>>> design/rcsfd_datapath.sv
// Datapath of the frame decoder: CRC, byte counter, channel store, output register.
// Depends on rcsfd_pkg (constants, cmd_t, sts_t, crc_add).
`default_nettype none

module rcsfd_datapath (
  input  wire logic                              clk_i,
  input  wire logic                              rst_ni,
  input  wire logic [7:0]                        rx_byte_i,
  input  rcsfd_pkg::cmd_t                        cmd_i,
  output rcsfd_pkg::sts_t                        sts_o,
  output logic                                   out_valid_o,
  input  wire logic                              out_ready_i,
  output logic [4:0]                             out_index_o,
  output logic [15:0]                            out_value_o,
  output logic [5:0]                             out_total_o,
  output logic                                   out_failsafe_o,
  output logic                                   out_crc_ok_o,
  output logic                                   out_last_o
);
  import rcsfd_pkg::*;

  logic [15:0]      crc_q, crc_d;
  logic [5:0]       n_q, n_d;
  logic [6:0]       pos_q, pos_d;
  logic [7:0]       pend_q, pend_d;
  logic             fs_q, fs_d;
  logic             crc_ok_q;
  logic [IDX_W-1:0] emit_idx_q;
  logic             valid_q;
  logic [15:0]      store_q [MAX_CHANNELS];

  logic [15:0]      crc_next;
  logic [6:0]       two_n;
  logic             in_data, in_crc_hi;

  assign crc_next  = crc_add(crc_q, rx_byte_i);
  assign two_n     = {n_q, 1'b0};
  assign in_data   = (pos_q < two_n);
  assign in_crc_hi = (pos_q == two_n);

  assign sts_o.is_start   = (rx_byte_i == START_BYTE);
  assign sts_o.status_ok  = (rx_byte_i == STATUS_LIVE) || (rx_byte_i == STATUS_FAILSAFE);
  assign sts_o.count_ok   = (rx_byte_i >= MIN_COUNT) && (rx_byte_i <= MAX_COUNT);
  assign sts_o.final_byte = !in_data && !in_crc_hi;
  assign sts_o.emit_last  = ((6'(emit_idx_q) + 6'd1) == n_q);
  assign sts_o.out_free   = !valid_q || out_ready_i;

  always_comb begin
    crc_d  = crc_q;
    n_d    = n_q;
    pos_d  = pos_q;
    pend_d = pend_q;
    fs_d   = fs_q;
    if (cmd_i.hunt_start) begin
      crc_d = crc_add(16'h0000, rx_byte_i);
      n_d   = '0;
      pos_d = '0;
    end
    if (cmd_i.status_take) begin
      fs_d  = (rx_byte_i == STATUS_FAILSAFE);
      crc_d = crc_next;
    end
    if (cmd_i.count_take) begin
      n_d   = rx_byte_i[5:0];
      crc_d = crc_next;
      pos_d = '0;
    end
    if (cmd_i.data_take) begin
      if (in_data) begin
        crc_d = crc_next;
        if (!pos_q[0]) pend_d = rx_byte_i;
        pos_d = pos_q + 7'd1;
      end else if (in_crc_hi) begin
        pend_d = rx_byte_i;
        pos_d  = pos_q + 7'd1;
      end else begin
        pos_d = '0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      crc_q      <= '0;
      n_q        <= '0;
      pos_q      <= '0;
      pend_q     <= '0;
      fs_q       <= 1'b0;
      crc_ok_q   <= 1'b0;
      emit_idx_q <= '0;
      valid_q    <= 1'b0;
    end else begin
      crc_q  <= crc_d;
      n_q    <= n_d;
      pos_q  <= pos_d;
      pend_q <= pend_d;
      fs_q   <= fs_d;
      // final CRC byte: latch the compare and rewind the emit pointer
      if (cmd_i.data_take && !in_data && !in_crc_hi) begin
        crc_ok_q   <= ({pend_q, rx_byte_i} == crc_q);
        emit_idx_q <= '0;
      end else if (cmd_i.emit_step) begin
        emit_idx_q <= emit_idx_q + IDX_W'(1);
      end
      if (cmd_i.emit_step) begin
        valid_q <= 1'b1;
      end else if (out_ready_i) begin
        valid_q <= 1'b0;
      end
    end
  end

  // channel store, written on the low byte of each channel
  always_ff @(posedge clk_i) begin
    if (cmd_i.data_take && in_data && pos_q[0]) begin
      store_q[pos_q[IDX_W:1]] <= {pend_q, rx_byte_i};
    end
  end

  // output payload register
  always_ff @(posedge clk_i) begin
    if (cmd_i.emit_step) begin
      out_index_o    <= 5'(emit_idx_q);
      out_value_o    <= store_q[emit_idx_q];
      out_total_o    <= n_q;
      out_failsafe_o <= fs_q;
      out_crc_ok_o   <= crc_ok_q;
      out_last_o     <= sts_o.emit_last;
    end
  end

  assign out_valid_o = valid_q;

endmodule

`default_nettype wire

>>> design/rc_serial_frame_decoder_unit.sv
// Top level of the radio control serial frame decoder (SUMD-style, CRC-16).
// Channels:
//   s_axis  - one received serial byte per item (tdata[7:0]).
//   m_axis  - one decoded channel per item; tlast marks the last channel of
//             a frame, tuser carries the failsafe and CRC-match flags.
// The frame is start 0xA8, status 0x01 or 0x81, a count of 2..MAX_CHANNELS,
// two bytes per channel (high first) and a CRC-16 (poly 0x1021, init 0) over
// header and data, high byte first.
// The final CRC byte moves the control to its emit state, which loads the
// first channel into the output register once that register is free; then
// one channel per cycle while m_axis_tready_i is high. The emitter walks the
// channel store one entry a cycle while the output is not stalled;
// s_axis_tready_o is low during that walk.
// If the receiver stalls, the output register holds its item and the walk
// waits; input stays blocked until the last channel is loaded.
// A CRC mismatch still emits the frame with crc_ok cleared.
// Reset (rst_ni low, asynchronous) returns to hunting for the start byte and
// drops any pending output item.
// Depends on rcsfd_pkg, rcsfd_ctrl, rcsfd_datapath.
`default_nettype none

module rc_serial_frame_decoder_unit (
  input  wire logic                              clk_i,
  input  wire logic                              rst_ni,
  input  wire logic                              s_axis_tvalid_i,
  output logic                                   s_axis_tready_o,
  input  wire logic [rcsfd_pkg::IN_TDATA_W-1:0]  s_axis_tdata_i,  // [7:0] rx_byte
  output logic                                   m_axis_tvalid_o,
  input  wire logic                              m_axis_tready_i,
  // [4:0] channel_index, [20:5] channel_value, [26:21] channel_total, [31:27] zero
  output logic [rcsfd_pkg::OUT_TDATA_W-1:0]      m_axis_tdata_o,
  output logic [rcsfd_pkg::OUT_TUSER_W-1:0]      m_axis_tuser_o,  // [0] failsafe, [1] crc_ok
  output logic                                   m_axis_tlast_o
);
  import rcsfd_pkg::*;

  cmd_t        cmd;
  sts_t        sts;
  logic [4:0]  out_index;
  logic [15:0] out_value;
  logic [5:0]  out_total;
  logic        out_failsafe;
  logic        out_crc_ok;

  rcsfd_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (s_axis_tvalid_i),
    .in_ready_o (s_axis_tready_o),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  rcsfd_datapath u_dp (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .rx_byte_i      (s_axis_tdata_i),
    .cmd_i          (cmd),
    .sts_o          (sts),
    .out_valid_o    (m_axis_tvalid_o),
    .out_ready_i    (m_axis_tready_i),
    .out_index_o    (out_index),
    .out_value_o    (out_value),
    .out_total_o    (out_total),
    .out_failsafe_o (out_failsafe),
    .out_crc_ok_o   (out_crc_ok),
    .out_last_o     (m_axis_tlast_o)
  );

  assign m_axis_tdata_o = {5'b00000, out_total, out_value, out_index};
  assign m_axis_tuser_o = {out_crc_ok, out_failsafe};

endmodule

`default_nettype wire

>>> design/rcsfd_checker.sv
// Port-level checker of the frame decoder, bound to the top level.
// Depends on rcsfd_pkg and rc_serial_frame_decoder_unit_defines.svh.
`default_nettype none
`include "rc_serial_frame_decoder_unit_defines.svh"

module rcsfd_checker (
  input wire logic                              clk_i,
  input wire logic                              rst_ni,
  input wire logic                              s_axis_tready_o,
  input wire logic                              m_axis_tvalid_o,
  input wire logic                              m_axis_tready_i,
  input wire logic [rcsfd_pkg::OUT_TDATA_W-1:0] m_axis_tdata_o,
  input wire logic [rcsfd_pkg::OUT_TUSER_W-1:0] m_axis_tuser_o,
  input wire logic                              m_axis_tlast_o
);
  import rcsfd_pkg::*;

  // stalled result holds
  `RCSFD_ASSERT(a_out_hold, clk_i, rst_ni,
    (m_axis_tvalid_o && !m_axis_tready_i) |=>
      (m_axis_tvalid_o && $stable(m_axis_tdata_o) && $stable(m_axis_tuser_o)
       && $stable(m_axis_tlast_o)),
    "output item changed under stall")

  // last channel of a frame has index total-1
  `RCSFD_IMPLY(a_last_index, clk_i, rst_ni, m_axis_tvalid_o && m_axis_tlast_o,
    (6'(m_axis_tdata_o[4:0]) + 6'd1) == m_axis_tdata_o[26:21],
    "tlast on wrong channel")

  // announced count stays within the legal range and the index stays below it
  `RCSFD_IMPLY(a_total_range, clk_i, rst_ni, m_axis_tvalid_o,
    (m_axis_tdata_o[26:21] >= 6'd2) && (m_axis_tdata_o[26:21] <= 6'(MAX_CHANNELS))
      && (6'(m_axis_tdata_o[4:0]) < m_axis_tdata_o[26:21]),
    "channel count or index out of range")

  // no byte taken while a frame is still being emitted
  `RCSFD_IMPLY(a_no_input_mid_emit, clk_i, rst_ni, m_axis_tvalid_o && !m_axis_tlast_o,
    !s_axis_tready_o, "input accepted during frame emission")

endmodule

bind rc_serial_frame_decoder_unit rcsfd_checker u_rcsfd_checker (.*);

`default_nettype wire

>>> verif/testbench.sv
`timescale 1ns / 1ps
// Self-checking bench for rc_serial_frame_decoder_unit: byte streams with good, corrupted,
// truncated and malformed frames in, decoded channel items checked against a local decoder.
// Depends on rcsfd_pkg and the decoder RTL.
module testbench;
  import rcsfd_pkg::*;

  localparam int unsigned CYCLE_LIMIT  = 200000;
  localparam int unsigned HOLD_CYCLES  = 300;
  localparam int unsigned DRAIN_CYCLES = 24;
  localparam int unsigned MAX_REPORTS  = 10;
  localparam int unsigned RANDOM_ITEMS = 100;

  typedef enum logic [1:0] {PH_HUNT, PH_STATUS, PH_COUNT, PH_DATA} phase_e;
  typedef enum int {FILL_RANDOM, FILL_EXTREMES, FILL_START_LOOKALIKE} fill_e;

  // One decoded channel as it leaves the block.
  typedef struct packed {
    logic [4:0]  index;
    logic [15:0] value;
    logic [5:0]  total;
    logic        failsafe;
    logic        crc_ok;
    logic        last;
  } channel_t;

  logic                   clk     = 1'b0;
  logic                   rst_n   = 1'b0;
  logic                   s_valid = 1'b0;
  logic [IN_TDATA_W-1:0]  s_data  = '0;
  logic                   s_ready;
  logic                   m_valid;
  logic                   m_ready = 1'b0;
  logic [OUT_TDATA_W-1:0] m_data;
  logic [OUT_TUSER_W-1:0] m_user;
  logic                   m_last;

  // Bench control and bookkeeping.
  logic        idle_en        = 1'b1;
  int unsigned hold_left      = 0;
  int unsigned rx_burst       = 0;
  int unsigned cycle_count    = 0;
  int unsigned items_accepted = 0;
  int unsigned frames_sent    = 0;
  int unsigned channels_checked = 0;
  int unsigned mismatches     = 0;
  channel_t    pending_results[$];

  // Local copy of the decoder state.
  phase_e      frm_phase    = PH_HUNT;
  logic [5:0]  frm_count    = '0;
  logic [6:0]  frm_pos      = '0;
  logic [15:0] frm_crc      = '0;
  logic [7:0]  frm_high     = '0;
  logic        frm_failsafe = 1'b0;
  logic [15:0] frm_store [MAX_CHANNELS];

  rc_serial_frame_decoder_unit dut (
    .clk_i           (clk),
    .rst_ni          (rst_n),
    .s_axis_tvalid_i (s_valid),
    .s_axis_tready_o (s_ready),
    .s_axis_tdata_i  (s_data),
    .m_axis_tvalid_o (m_valid),
    .m_axis_tready_i (m_ready),
    .m_axis_tdata_o  (m_data),
    .m_axis_tuser_o  (m_user),
    .m_axis_tlast_o  (m_last)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // CRC-16/0x1021, init 0, shifted one message bit at a time, MSB first.
  function automatic logic [15:0] crc16_byte(input logic [15:0] crc_in, input logic [7:0] data);
    logic [15:0] r;
    logic        fb;
    r = crc_in;
    for (int k = 7; k >= 0; k--) begin
      fb = r[15] ^ data[k];
      r  = {r[14:0], 1'b0};
      if (fb) begin
        r = r ^ CRC_POLY;
      end
    end
    return r;
  endfunction

  // Advance the local decoder by one accepted byte; queue the channels a frame end releases.
  function automatic void decode_rx_byte(input logic [7:0] b);
    channel_t    ch;
    logic [15:0] rx_word;
    int unsigned idx;
    case (frm_phase)
      PH_HUNT: begin
        if (b == START_BYTE) begin
          frm_crc   = crc16_byte(16'h0000, b);
          frm_count = '0;
          frm_pos   = '0;
          frm_phase = PH_STATUS;
        end
      end
      PH_STATUS: begin
        // a rejected status byte is not retried as a start
        if (b == STATUS_LIVE || b == STATUS_FAILSAFE) begin
          frm_failsafe = (b == STATUS_FAILSAFE);
          frm_crc      = crc16_byte(frm_crc, b);
          frm_phase    = PH_COUNT;
        end else begin
          frm_phase = PH_HUNT;
        end
      end
      PH_COUNT: begin
        if (b >= MIN_COUNT && b <= MAX_COUNT) begin
          frm_count = b[5:0];
          frm_crc   = crc16_byte(frm_crc, b);
          frm_pos   = '0;
          frm_phase = PH_DATA;
        end else begin
          frm_phase = PH_HUNT;
        end
      end
      default: begin
        // data bytes, then CRC high, then CRC low; a start byte here is plain data
        if (int'(frm_pos) < 2 * int'(frm_count)) begin
          frm_crc = crc16_byte(frm_crc, b);
          idx     = 32'(frm_pos[6:1]);
          if (!frm_pos[0]) begin
            frm_high = b;
          end else if (idx < MAX_CHANNELS) begin
            frm_store[idx] = {frm_high, b};
          end
          frm_pos = frm_pos + 7'd1;
        end else if (int'(frm_pos) == 2 * int'(frm_count)) begin
          frm_high = b;
          frm_pos  = frm_pos + 7'd1;
        end else begin
          rx_word = {frm_high, b};
          for (int unsigned i = 0; i < 32'(frm_count) && i < MAX_CHANNELS; i++) begin
            ch.index    = 5'(i);
            ch.value    = frm_store[i];
            ch.total    = frm_count;
            ch.failsafe = frm_failsafe;
            ch.crc_ok   = (rx_word == frm_crc);
            ch.last     = (i + 1 == 32'(frm_count));
            pending_results.push_back(ch);
          end
          frm_phase = PH_HUNT;
          frm_pos   = '0;
        end
      end
    endcase
  endfunction

  function automatic void note_mismatch(input string what, input logic [31:0] want,
                                        input logic [31:0] got);
    mismatches++;
    if (mismatches <= MAX_REPORTS) begin
      $display("mismatch %0d at cycle %0d: %s expected 0x%0h got 0x%0h",
               mismatches, cycle_count, what, want, got);
    end
  endfunction

  function automatic void check_channel();
    channel_t want, got;
    got.index    = m_data[4:0];
    got.value    = m_data[20:5];
    got.total    = m_data[26:21];
    got.failsafe = m_user[0];
    got.crc_ok   = m_user[1];
    got.last     = m_last;
    if (m_data[OUT_TDATA_W-1:27] != '0) begin
      note_mismatch("tdata padding", 32'h0, 32'(m_data[OUT_TDATA_W-1:27]));
    end
    if (pending_results.size() == 0) begin
      note_mismatch("channel item with nothing expected", 32'h0, 32'(got));
      return;
    end
    want = pending_results.pop_front();
    channels_checked++;
    if (got.index != want.index) begin
      note_mismatch("channel_index", 32'(want.index), 32'(got.index));
    end
    if (got.value != want.value) begin
      note_mismatch("channel_value", 32'(want.value), 32'(got.value));
    end
    if (got.total != want.total) begin
      note_mismatch("channel_total", 32'(want.total), 32'(got.total));
    end
    if (got.failsafe != want.failsafe) begin
      note_mismatch("failsafe", 32'(want.failsafe), 32'(got.failsafe));
    end
    if (got.crc_ok != want.crc_ok) begin
      note_mismatch("crc_ok", 32'(want.crc_ok), 32'(got.crc_ok));
    end
    if (got.last != want.last) begin
      note_mismatch("last", 32'(want.last), 32'(got.last));
    end
  endfunction

  // Receiver: check on every handshake, then pick next tready from bursts and the long hold.
  always @(posedge clk) begin
    if (rst_n && m_valid && m_ready) begin
      check_channel();
    end
    if (rx_burst != 0) begin
      rx_burst--;
    end else if (idle_en && $urandom_range(0, 5) == 0) begin
      rx_burst = $urandom_range(1, 9);
    end
    m_ready <= (rx_burst == 0) && (hold_left == 0);
  end

  // Long receiver hold-off, counted down here.
  always @(posedge clk) begin
    if (hold_left != 0) begin
      hold_left <= hold_left - 1;
    end
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d channel items still expected",
               cycle_count, pending_results.size());
      $display("CHECKS FAILED");
      $finish;
    end
  end

  // Offer one byte, hold it until taken, then feed it to the local decoder.
  task automatic send_byte(input logic [7:0] b);
    int unsigned gap;
    if (idle_en && $urandom_range(0, 3) == 0) begin
      gap = $urandom_range(1, 9);
      s_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    s_valid <= 1'b1;
    s_data  <= b;
    @(posedge clk);
    while (!s_ready) @(posedge clk);
    decode_rx_byte(b);
    items_accepted++;
  endtask

  // Build a frame with a correct CRC (or a corrupted one); keep != 0 cuts it short.
  task automatic send_frame(input logic [7:0] status, input int unsigned nch, input fill_e fill,
                            input bit bad_crc, input int unsigned keep = 0);
    logic [7:0]  frame_bytes[$];
    logic [15:0] crc;
    logic [15:0] word;
    frame_bytes = {START_BYTE, status, 8'(nch)};
    for (int unsigned i = 0; i < nch; i++) begin
      case (fill)
        FILL_EXTREMES:        word = i[0] ? 16'hFFFF : 16'h0000;
        FILL_START_LOOKALIKE: word = {START_BYTE, i[0] ? STATUS_FAILSAFE : 8'(nch)};
        default:              word = 16'($urandom);
      endcase
      frame_bytes.push_back(word[15:8]);
      frame_bytes.push_back(word[7:0]);
    end
    crc = 16'h0000;
    foreach (frame_bytes[k]) crc = crc16_byte(crc, frame_bytes[k]);
    if (bad_crc) begin
      crc ^= 16'($urandom_range(1, 16'hFFFF));
    end
    frame_bytes.push_back(crc[15:8]);
    frame_bytes.push_back(crc[7:0]);
    if (keep != 0 && keep < frame_bytes.size()) begin
      frame_bytes = frame_bytes[0:keep-1];
    end
    foreach (frame_bytes[k]) send_byte(frame_bytes[k]);
    frames_sent++;
  endtask

  task automatic wait_for_results();
    s_valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
  endtask

  // Noise while hunting, rejected status and count bytes that must not restart a frame.
  task automatic test_header_rejects();
    send_byte(8'h00);
    send_byte(8'hFF);
    send_byte(START_BYTE);
    send_byte(START_BYTE);          // bad status, not a new start
    send_byte(STATUS_LIVE);         // ignored while hunting
    send_byte(START_BYTE);
    send_byte(STATUS_LIVE);
    send_byte(MIN_COUNT - 8'd1);    // count below range
    send_byte(START_BYTE);
    send_byte(STATUS_FAILSAFE);
    send_byte(START_BYTE);          // count above range, not a new start
    send_byte(STATUS_LIVE);
    send_byte(MIN_COUNT);
  endtask

  // Smallest frames: extreme values with good CRC, start lookalikes in data with bad CRC.
  task automatic test_directed_frames();
    send_frame(STATUS_LIVE, 2, FILL_EXTREMES, 1'b0);
    send_frame(STATUS_FAILSAFE, 2, FILL_START_LOOKALIKE, 1'b1);
  endtask

  // Mostly well-formed frames with random content, plus noise, broken headers and cut frames.
  task automatic test_random_traffic();
    int unsigned target;
    int unsigned kind;
    int unsigned nch;
    int unsigned noise_n;
    logic [7:0]  status;
    target = items_accepted + RANDOM_ITEMS;
    while (items_accepted < target) begin
      kind   = $urandom_range(0, 19);
      status = $urandom_range(0, 1) ? STATUS_FAILSAFE : STATUS_LIVE;
      case ($urandom_range(0, 7))
        0:       nch = MAX_CHANNELS;
        1, 2:    nch = $urandom_range(2, MAX_CHANNELS);
        default: nch = $urandom_range(2, 4);
      endcase
      if (kind < 14) begin
        send_frame(status, nch, FILL_RANDOM, $urandom_range(0, 6) == 0);
      end else if (kind < 16) begin
        noise_n = $urandom_range(1, 5);
        repeat (noise_n) send_byte(8'($urandom));
      end else if (kind < 18) begin
        send_byte(START_BYTE);
        send_byte(8'($urandom));
        if ($urandom_range(0, 1)) begin
          send_byte(8'($urandom));
        end
      end else begin
        // cut frame: whatever follows is taken as its data
        send_frame(status, nch, FILL_RANDOM, 1'b0, $urandom_range(4, 2 * nch + 4));
      end
    end
  endtask

  // Receiver holds off while two full-size frames arrive: the walk stalls and input backs up.
  task automatic test_output_backpressure();
    hold_left <= HOLD_CYCLES;
    send_frame(STATUS_LIVE, MAX_CHANNELS, FILL_RANDOM, 1'b0);
    send_frame(STATUS_FAILSAFE, MAX_CHANNELS, FILL_START_LOOKALIKE, 1'b1);
    wait_for_results();
  endtask

  // Back-to-back frames with no idling on either side.
  task automatic test_steady_stream();
    idle_en = 1'b0;
    send_frame(STATUS_FAILSAFE, 3, FILL_RANDOM, 1'b0);
    send_frame(STATUS_LIVE, 3, FILL_RANDOM, 1'b0);
  endtask

  initial begin
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_header_rejects();
    test_directed_frames();
    test_random_traffic();
    test_output_backpressure();
    test_steady_stream();
    wait_for_results();
    repeat (DRAIN_CYCLES) @(posedge clk);
    $display("Run: %0d bytes taken, %0d frames offered, %0d channel items checked.",
             items_accepted, frames_sent, channels_checked);
    $display("Covered header rejects, good/bad CRC, cut frames, a long output stall, no-idle run.");
    if (mismatches == 0 && pending_results.size() == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule

>>> filelist.f
+incdir+design
design/rcsfd_pkg.sv
design/rcsfd_ctrl.sv
design/rcsfd_datapath.sv
design/rc_serial_frame_decoder_unit.sv
design/rcsfd_checker.sv
verif/testbench.sv
